// ===== src/char_lcd_nibble_bus_controller_unit_macros.svh =====
// assertion macros shared by the lcd nibble bus controller rtl
`ifndef CHAR_LCD_NIBBLE_BUS_CONTROLLER_UNIT_MACROS_SVH
`define CHAR_LCD_NIBBLE_BUS_CONTROLLER_UNIT_MACROS_SVH

// same-cycle check, held off while reset is low
`define LCDNB_CHECK(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle check, held off while reset is low
`define LCDNB_CHECK_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/lcdnb_pkg.sv =====
// types, register indexes and constants of the lcd nibble bus controller
package lcdnb_pkg;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON_WAIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_GAP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT  = 3'd4;

    localparam logic [19:0] RST_POWER_ON_WAIT = 20'd50000;
    localparam logic [19:0] RST_INIT_GAP      = 20'd5000;
    localparam logic [7:0]  RST_ENABLE_PULSE  = 8'd4;
    localparam logic [7:0]  RST_NIBBLE_GAP    = 8'd2;
    localparam logic [15:0] RST_BUSY_TIMEOUT  = 16'd0;

    localparam logic [7:0]  BUSY_MASK      = 8'h80;
    localparam logic [3:0]  NIB_INIT       = 4'h3;
    localparam logic [3:0]  NIB_INIT_LAST  = 4'h2;
    localparam logic [2:0]  RAW_LAST_STEP  = 3'd3;
    localparam logic [2:0]  CMD_FIRST_STEP = 3'd4;
    localparam logic [2:0]  CMD_LAST_STEP  = 3'd7;
    localparam logic [15:0] WAIT_MAX       = 16'hFFFF;

    // command bytes sent after the raw nibbles
    localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h0C, 8'h04, 8'h01};

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_PWR       = 4'd1,
        PH_RAW_PULSE = 4'd2,
        PH_RAW_GAP   = 4'd3,
        PH_POLL_HI   = 4'd4,
        PH_POLL_GAP1 = 4'd5,
        PH_POLL_LO   = 4'd6,
        PH_POLL_GAP2 = 4'd7,
        PH_WR_HI     = 4'd8,
        PH_WR_GAP    = 4'd9,
        PH_WR_LO     = 4'd10,
        PH_RD_HI     = 4'd11,
        PH_RD_GAP    = 4'd12,
        PH_RD_LO     = 4'd13,
        PH_END       = 4'd14
    } t_phase;

    typedef struct packed {
        t_op        op;
        logic [7:0] byte_value;
        logic       reg_select;
        logic [3:0] pins_in;
    } t_in_item;

    typedef struct packed {
        logic       enable_out;
        logic       rs_out;
        logic       rw_out;
        logic [3:0] data_out;
        logic       drive_on;
        logic [7:0] read_data;
        logic       done_res;
        logic       timed_out;
        logic       rejected;
        logic       idle;
    } t_out_item;

    typedef struct packed {
        logic [19:0] power_on_wait_ticks;
        logic [19:0] init_gap_ticks;
        logic [7:0]  enable_pulse_ticks;
        logic [7:0]  nibble_gap_ticks;
        logic [15:0] busy_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  init_step;
        logic [19:0] delay_count;
        logic [15:0] wait_elapsed;
        logic [7:0]  byte_latch;
        logic        select_latch;
        logic [7:0]  read_assembly;
        t_op         request_kind;
    } t_seq_state;

    typedef struct packed {
        t_seq_state st;
        logic       done;
        logic       tout;
    } t_step;

    typedef struct packed {
        logic       en;
        logic       rs;
        logic       rw;
        logic [3:0] d;
        logic       drv;
    } t_lines;

endpackage

// ===== src/lcdnb_cfg_regs.sv =====
// configuration register file with its reset values
module lcdnb_cfg_regs
    import lcdnb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POWER_ON_WAIT: n_cfg.power_on_wait_ticks = i_cfg_data[19:0];
                CFG_INIT_GAP:      n_cfg.init_gap_ticks      = i_cfg_data[19:0];
                CFG_ENABLE_PULSE:  n_cfg.enable_pulse_ticks  = i_cfg_data[7:0];
                CFG_NIBBLE_GAP:    n_cfg.nibble_gap_ticks    = i_cfg_data[7:0];
                CFG_BUSY_TIMEOUT:  n_cfg.busy_timeout_ticks  = i_cfg_data[15:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_on_wait_ticks <= RST_POWER_ON_WAIT;
            r_cfg.init_gap_ticks      <= RST_INIT_GAP;
            r_cfg.enable_pulse_ticks  <= RST_ENABLE_PULSE;
            r_cfg.nibble_gap_ticks    <= RST_NIBBLE_GAP;
            r_cfg.busy_timeout_ticks  <= RST_BUSY_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/lcdnb_seq.sv =====
// pin sequencer: phase state, timing counters and line levels
module lcdnb_seq
    import lcdnb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_seq_state r_st;
    t_seq_state n_st;
    t_seq_state req;
    t_seq_state tk;
    t_seq_state mid;
    t_step      first;
    t_step      second;
    t_lines     lv;
    logic       done;
    logic       tout;
    logic       rej;

    function automatic logic [19:0] phase_len(t_phase ph, t_cfg cfg);
        logic [7:0]  e;
        logic [19:0] len;
        e = (cfg.enable_pulse_ticks == 8'd0) ? 8'd1 : cfg.enable_pulse_ticks;
        case (ph)
            PH_PWR:     len = cfg.power_on_wait_ticks;
            PH_RAW_GAP: len = cfg.init_gap_ticks;
            PH_RAW_PULSE, PH_POLL_HI, PH_POLL_LO, PH_WR_HI, PH_WR_LO,
            PH_RD_HI, PH_RD_LO:
                        len = {12'd0, e};
            PH_POLL_GAP1, PH_POLL_GAP2, PH_WR_GAP, PH_RD_GAP:
                        len = {12'd0, cfg.nibble_gap_ticks};
            default:    len = 20'd1;
        endcase
        return len;
    endfunction

    // leaves the current phase; every move restarts the delay counter
    function automatic t_step exit_phase(t_seq_state s, t_cfg cfg, logic [3:0] pins);
        t_step      r;
        logic [2:0] nstep;
        logic       expired;
        r       = '0;
        r.st    = s;
        r.st.delay_count = '0;
        nstep   = s.init_step + 3'd1;
        expired = (cfg.busy_timeout_ticks != 16'd0)
                  && (s.wait_elapsed > cfg.busy_timeout_ticks);
        case (s.phase)
            PH_PWR:       r.st.phase = PH_RAW_PULSE;
            PH_RAW_PULSE: r.st.phase = PH_RAW_GAP;
            PH_RAW_GAP: begin
                r.st.init_step = nstep;
                if (nstep < CMD_FIRST_STEP) begin
                    r.st.phase = PH_RAW_PULSE;
                end else begin
                    r.st.byte_latch   = INIT_CMDS[nstep[1:0]];
                    r.st.select_latch = 1'b0;
                    r.st.wait_elapsed = '0;
                    r.st.phase        = PH_POLL_HI;
                end
            end
            PH_POLL_HI: begin
                r.st.read_assembly = {pins, 4'd0};
                r.st.phase         = PH_POLL_GAP1;
            end
            PH_POLL_GAP1: r.st.phase = PH_POLL_LO;
            PH_POLL_LO: begin
                r.st.read_assembly = {s.read_assembly[7:4], pins};
                r.st.phase         = PH_POLL_GAP2;
            end
            PH_POLL_GAP2: begin
                if (((s.read_assembly & BUSY_MASK) != 8'd0) && !expired) begin
                    r.st.phase = PH_POLL_HI;
                end else begin
                    r.tout     = ((s.read_assembly & BUSY_MASK) != 8'd0);
                    r.st.phase = (s.request_kind == OP_READ) ? PH_RD_HI : PH_WR_HI;
                end
            end
            PH_WR_HI:  r.st.phase = PH_WR_GAP;
            PH_WR_GAP: r.st.phase = PH_WR_LO;
            PH_WR_LO:  r.st.phase = PH_END;
            PH_RD_HI: begin
                r.st.read_assembly = {pins, 4'd0};
                r.st.phase         = PH_RD_GAP;
            end
            PH_RD_GAP: r.st.phase = PH_RD_LO;
            PH_RD_LO: begin
                r.st.read_assembly = {s.read_assembly[7:4], pins};
                r.st.phase         = PH_END;
            end
            PH_END: begin
                if (s.request_kind == OP_INIT && s.init_step >= CMD_FIRST_STEP
                        && s.init_step < CMD_LAST_STEP) begin
                    r.st.init_step    = nstep;
                    r.st.byte_latch   = INIT_CMDS[nstep[1:0]];
                    r.st.wait_elapsed = '0;
                    r.st.phase        = PH_POLL_HI;
                end else begin
                    r.done     = 1'b1;
                    r.st.phase = PH_IDLE;
                end
            end
            default: r.st.phase = PH_IDLE;
        endcase
        return r;
    endfunction

    function automatic t_lines levels(t_seq_state s);
        t_lines l;
        l = '0;
        if (s.phase >= PH_POLL_HI && s.phase <= PH_POLL_GAP2) begin
            l.rw = 1'b1;
            l.en = (s.phase == PH_POLL_HI) || (s.phase == PH_POLL_LO);
        end else if (s.phase >= PH_RD_HI && s.phase <= PH_RD_LO) begin
            l.rs = s.select_latch;
            l.rw = 1'b1;
            l.en = (s.phase != PH_RD_GAP);
        end else if (s.phase >= PH_WR_HI && s.phase <= PH_WR_LO) begin
            l.rs = s.select_latch;
            if (s.phase != PH_WR_GAP) begin
                l.en  = 1'b1;
                l.drv = 1'b1;
                l.d   = (s.phase == PH_WR_HI) ? s.byte_latch[7:4] : s.byte_latch[3:0];
            end
        end else if (s.phase == PH_RAW_PULSE) begin
            l.en  = 1'b1;
            l.drv = 1'b1;
            l.d   = (s.init_step == RAW_LAST_STEP) ? NIB_INIT_LAST : NIB_INIT;
        end else if (s.phase == PH_END) begin
            l.rs = s.select_latch;
        end
        return l;
    endfunction

    always_comb begin
        n_st   = r_st;
        req    = r_st;
        tk     = r_st;
        mid    = r_st;
        first  = '0;
        second = '0;
        done   = 1'b0;
        tout   = 1'b0;
        rej    = 1'b0;
        lv     = levels(r_st);
        if (i_item.op != OP_TICK) begin
            if (r_st.phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                req.request_kind = i_item.op;
                req.select_latch = i_item.reg_select;
                req.delay_count  = '0;
                if (i_item.op == OP_INIT) begin
                    req.init_step    = '0;
                    req.select_latch = 1'b0;
                    req.phase        = PH_PWR;
                end else begin
                    req.byte_latch   = i_item.byte_value;
                    req.wait_elapsed = '0;
                    req.phase        = PH_POLL_HI;
                end
                // a zero power-on wait goes straight to the first nibble
                first = exit_phase(req, i_cfg, i_item.pins_in);
                if (phase_len(req.phase, i_cfg) == 20'd0) begin
                    n_st = first.st;
                end else begin
                    n_st = req;
                end
                lv = levels(n_st);
            end
        end else if (r_st.phase != PH_IDLE) begin
            if (r_st.phase >= PH_POLL_HI && r_st.phase <= PH_POLL_GAP2
                    && r_st.wait_elapsed != WAIT_MAX) begin
                tk.wait_elapsed = r_st.wait_elapsed + 16'd1;
            end
            tk.delay_count = r_st.delay_count + 20'd1;
            first = exit_phase(tk, i_cfg, i_item.pins_in);
            if (tk.delay_count >= phase_len(tk.phase, i_cfg)) begin
                mid  = first.st;
                done = first.done;
                tout = first.tout;
            end else begin
                mid = tk;
            end
            // at most one empty gap can follow an exit
            second = exit_phase(mid, i_cfg, i_item.pins_in);
            if (mid.phase != PH_IDLE && phase_len(mid.phase, i_cfg) == 20'd0) begin
                n_st = second.st;
                done = done | second.done;
                tout = tout | second.tout;
            end else begin
                n_st = mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase         <= PH_IDLE;
            r_st.init_step     <= '0;
            r_st.delay_count   <= '0;
            r_st.wait_elapsed  <= '0;
            r_st.byte_latch    <= '0;
            r_st.select_latch  <= 1'b0;
            r_st.read_assembly <= '0;
            r_st.request_kind  <= OP_TICK;
        end else if (i_fire) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        o_result.enable_out = lv.en;
        o_result.rs_out     = lv.rs;
        o_result.rw_out     = lv.rw;
        o_result.data_out   = lv.d;
        o_result.drive_on   = lv.drv;
        o_result.read_data  = (done && r_st.request_kind == OP_READ)
                              ? n_st.read_assembly : 8'd0;
        o_result.done_res   = done;
        o_result.timed_out  = tout;
        o_result.rejected   = rej;
        o_result.idle       = (n_st.phase == PH_IDLE);
    end

endmodule

// ===== src/char_lcd_nibble_bus_controller_unit.sv =====
// top level of the character lcd 4-bit bus controller
// throughput: one item per cycle while the output side takes results, one sequencer step per item
// the sequencer state advances when an item moves from the input register
// into the result register; the result register stalls only on the output side
// reset (synchronous, active low) empties both registers, idles the sequencer
// and loads the configuration registers with their default timings
`include "char_lcd_nibble_bus_controller_unit_macros.svh"

module char_lcd_nibble_bus_controller_unit
    import lcdnb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request and tick items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    // line levels and status per item
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    t_cfg      cfg;
    t_out_item result;

    // the held item moves on when the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    // the input register refills in the same cycle it empties
    assign o_in_ready = !r_in_valid || advance;

    lcdnb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // one sequencer step per item, state updated on advance
    lcdnb_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `LCDNB_CHECK_NEXT(a_step_lands, advance, r_out_valid, "stepped item did not reach the result register")
    `LCDNB_CHECK(a_done_idles, r_out_valid && r_out_item.done_res, r_out_item.idle, "finished request left the sequencer busy")
    `LCDNB_CHECK(a_timeout_busy, r_out_valid && r_out_item.timed_out, !r_out_item.idle && !r_out_item.done_res, "timeout reported outside a transfer")
    `LCDNB_CHECK(a_reject_quiet, r_out_valid && r_out_item.rejected, !r_out_item.done_res && !r_out_item.idle, "rejected request reported progress")
    `LCDNB_CHECK(a_drive_write, r_out_valid && r_out_item.drive_on, r_out_item.enable_out && !r_out_item.rw_out, "bus driven outside a write pulse")

endmodule

// ===== tb/testbench.sv =====
// testbench for the character lcd 4-bit bus controller: predicted line levels checked per item
`timescale 1ns / 1ps

module testbench;
    import lcdnb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moving on either side and no register write
    localparam int HOLD_OFF       = 300;   // long receiver hold-off in the pressure test
    localparam int PIPE_DRAIN     = 4;     // two registers deep plus margin
    localparam int END_WAIT       = 20;
    localparam int PHASE_ITEMS    = 350;   // working items per random phase
    localparam int LONG_POLL      = 400;   // poll ticks with the busy flag held up
    localparam int TX_IDLE [4]    = '{0, 52, 0, 32};
    localparam int RX_STALL [4]   = '{0, 0, 52, 32};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  dut_in_ready;
    t_in_item              in_item;
    logic                  dut_out_valid;
    logic                  out_ready;
    t_out_item             dut_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    char_lcd_nibble_bus_controller_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (dut_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (dut_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (dut_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // timing registers as the block should hold them
    logic [19:0] tm_pwr_wait  = RST_POWER_ON_WAIT;
    logic [19:0] tm_init_gap  = RST_INIT_GAP;
    logic [7:0]  tm_pulse     = RST_ENABLE_PULSE;
    logic [7:0]  tm_nib_gap   = RST_NIBBLE_GAP;
    logic [15:0] tm_busy_lim  = RST_BUSY_TIMEOUT;

    // sequencer state as the block should hold it
    t_phase      seq_phase     = PH_IDLE;
    logic [2:0]  seq_init_step = '0;
    logic [19:0] seq_delay     = '0;
    logic [15:0] seq_waited    = '0;
    logic [7:0]  seq_byte      = '0;
    logic        seq_sel       = 1'b0;
    logic [7:0]  seq_asm       = '0;
    t_op         seq_kind      = OP_TICK;

    // per-step flags raised while the sequencer moves
    logic        step_done;
    logic        step_tout;
    logic [7:0]  step_rdata;

    t_out_item   exp_levels_q [$];
    int          fail_count   = 0;
    int unsigned work_items   = 0;
    int          idle_cycles  = 0;

    // stimulus knobs
    int unsigned busy_pct     = 0;
    int unsigned noise_pct    = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int          rx_hold_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [19:0] phase_ticks(t_phase ph);
        case (ph)
            PH_PWR:     return tm_pwr_wait;
            PH_RAW_GAP: return tm_init_gap;
            PH_RAW_PULSE, PH_POLL_HI, PH_POLL_LO, PH_WR_HI, PH_WR_LO, PH_RD_HI, PH_RD_LO:
                return (tm_pulse == 8'd0) ? 20'd1 : 20'(tm_pulse);
            PH_POLL_GAP1, PH_POLL_GAP2, PH_WR_GAP, PH_RD_GAP:
                return 20'(tm_nib_gap);
            default:    return 20'd1;
        endcase
    endfunction

    function automatic void enter(t_phase ph);
        seq_phase = ph;
        seq_delay = '0;
    endfunction

    function automatic void start_byte();
        seq_waited = '0;
        enter(PH_POLL_HI);
    endfunction

    function automatic void leave_phase(logic [3:0] pins);
        logic busy;
        busy = (seq_asm & BUSY_MASK) != 8'd0;
        case (seq_phase)
            PH_PWR:       enter(PH_RAW_PULSE);
            PH_RAW_PULSE: enter(PH_RAW_GAP);
            PH_RAW_GAP: begin
                seq_init_step = seq_init_step + 3'd1;
                if (seq_init_step < CMD_FIRST_STEP) begin
                    enter(PH_RAW_PULSE);
                end else begin
                    seq_byte = INIT_CMDS[2'(seq_init_step - CMD_FIRST_STEP)];
                    seq_sel  = 1'b0;
                    start_byte();
                end
            end
            PH_POLL_HI: begin
                seq_asm = {pins, 4'h0};
                enter(PH_POLL_GAP1);
            end
            PH_POLL_GAP1: enter(PH_POLL_LO);
            PH_POLL_LO: begin
                seq_asm[3:0] = pins;
                enter(PH_POLL_GAP2);
            end
            PH_POLL_GAP2: begin
                // still busy: poll again unless a nonzero limit is strictly exceeded
                if (busy && !(tm_busy_lim != 16'd0 && seq_waited > tm_busy_lim)) begin
                    enter(PH_POLL_HI);
                end else begin
                    if (busy)
                        step_tout = 1'b1;
                    if (seq_kind == OP_READ)
                        enter(PH_RD_HI);
                    else
                        enter(PH_WR_HI);
                end
            end
            PH_WR_HI:  enter(PH_WR_GAP);
            PH_WR_GAP: enter(PH_WR_LO);
            PH_WR_LO:  enter(PH_END);
            PH_RD_HI: begin
                seq_asm = {pins, 4'h0};
                enter(PH_RD_GAP);
            end
            PH_RD_GAP: enter(PH_RD_LO);
            PH_RD_LO: begin
                seq_asm[3:0] = pins;
                enter(PH_END);
            end
            PH_END: begin
                // init chains its command bytes, everything else finishes here
                if (seq_kind == OP_INIT && seq_init_step >= CMD_FIRST_STEP
                        && seq_init_step < CMD_LAST_STEP) begin
                    seq_init_step = seq_init_step + 3'd1;
                    seq_byte = INIT_CMDS[2'(seq_init_step - CMD_FIRST_STEP)];
                    start_byte();
                end else begin
                    step_done  = 1'b1;
                    step_rdata = (seq_kind == OP_READ) ? seq_asm : 8'd0;
                    enter(PH_IDLE);
                end
            end
            default: enter(PH_IDLE);
        endcase
    endfunction

    // zero-length waits and gaps pass without a tick of their own
    function automatic void skip_zero_phases(logic [3:0] pins);
        while (seq_phase != PH_IDLE && phase_ticks(seq_phase) == 20'd0)
            leave_phase(pins);
    endfunction

    function automatic t_lines bus_lines();
        t_lines l;
        l = '0;
        if (seq_phase >= PH_POLL_HI && seq_phase <= PH_POLL_GAP2) begin
            l.rw = 1'b1;
            l.en = (seq_phase == PH_POLL_HI || seq_phase == PH_POLL_LO);
        end else if (seq_phase >= PH_RD_HI && seq_phase <= PH_RD_LO) begin
            l.rs = seq_sel;
            l.rw = 1'b1;
            l.en = (seq_phase != PH_RD_GAP);
        end else if (seq_phase >= PH_WR_HI && seq_phase <= PH_WR_LO) begin
            l.rs = seq_sel;
            if (seq_phase != PH_WR_GAP) begin
                l.en  = 1'b1;
                l.drv = 1'b1;
                l.d   = (seq_phase == PH_WR_HI) ? seq_byte[7:4] : seq_byte[3:0];
            end
        end else if (seq_phase == PH_RAW_PULSE) begin
            l.en  = 1'b1;
            l.drv = 1'b1;
            l.d   = (seq_init_step == RAW_LAST_STEP) ? NIB_INIT_LAST : NIB_INIT;
        end else if (seq_phase == PH_END) begin
            l.rs = seq_sel;
        end
        return l;
    endfunction

    function automatic t_out_item predict_bus_step(t_in_item it);
        t_out_item r;
        t_lines    ln;
        logic      rej;
        logic      was_busy;
        step_done  = 1'b0;
        step_tout  = 1'b0;
        step_rdata = 8'd0;
        rej        = 1'b0;
        was_busy   = (seq_phase != PH_IDLE);
        if (it.op != OP_TICK) begin
            if (was_busy) begin
                rej = 1'b1;
            end else begin
                seq_kind = it.op;
                seq_sel  = it.reg_select;
                if (it.op == OP_INIT) begin
                    seq_init_step = '0;
                    seq_sel = 1'b0;
                    enter(PH_PWR);
                end else begin
                    seq_byte = it.byte_value;
                    start_byte();
                end
                skip_zero_phases(it.pins_in);
            end
            ln = bus_lines();
        end else begin
            // levels of this tick first, then the sequencer steps
            ln = bus_lines();
            if (was_busy) begin
                if (seq_phase >= PH_POLL_HI && seq_phase <= PH_POLL_GAP2 && seq_waited != WAIT_MAX)
                    seq_waited = seq_waited + 16'd1;
                seq_delay = seq_delay + 20'd1;
                if (seq_delay >= phase_ticks(seq_phase))
                    leave_phase(it.pins_in);
                skip_zero_phases(it.pins_in);
            end
        end
        if ((it.op != OP_TICK && !rej) || (it.op == OP_TICK && was_busy))
            work_items++;
        r.enable_out = ln.en;
        r.rs_out     = ln.rs;
        r.rw_out     = ln.rw;
        r.data_out   = ln.d;
        r.drive_on   = ln.drv;
        r.read_data  = step_rdata;
        r.done_res   = step_done;
        r.timed_out  = step_tout;
        r.rejected   = rej;
        r.idle       = (seq_phase == PH_IDLE);
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void compare_levels(t_out_item want, t_out_item got);
        report_field("enable_out", 8'(want.enable_out), 8'(got.enable_out));
        report_field("rs_out",     8'(want.rs_out),     8'(got.rs_out));
        report_field("rw_out",     8'(want.rw_out),     8'(got.rw_out));
        report_field("data_out",   8'(want.data_out),   8'(got.data_out));
        report_field("drive_on",   8'(want.drive_on),   8'(got.drive_on));
        report_field("read_data",  want.read_data,      got.read_data);
        report_field("done_res",   8'(want.done_res),   8'(got.done_res));
        report_field("timed_out",  8'(want.timed_out),  8'(got.timed_out));
        report_field("rejected",   8'(want.rejected),   8'(got.rejected));
        report_field("idle",       8'(want.idle),       8'(got.idle));
    endfunction

    // one process at the rising edge: register writes, prediction, result check, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_POWER_ON_WAIT: tm_pwr_wait = cfg_data[19:0];
                    CFG_INIT_GAP:      tm_init_gap = cfg_data[19:0];
                    CFG_ENABLE_PULSE:  tm_pulse    = cfg_data[7:0];
                    CFG_NIBBLE_GAP:    tm_nib_gap  = cfg_data[7:0];
                    CFG_BUSY_TIMEOUT:  tm_busy_lim = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_valid && dut_in_ready)
                exp_levels_q.push_back(predict_bus_step(in_item));
            if (dut_out_valid && out_ready) begin
                if (exp_levels_q.size() == 0) begin
                    $display("%0t unexpected item expected none actual %h", $time, dut_out);
                    fail_count++;
                end else begin
                    compare_levels(exp_levels_q.pop_front(), dut_out);
                end
            end
            if ((in_valid && dut_in_ready) || (dut_out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            out_ready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // every task ends at a falling edge, and all but reset_block also start at one
    task automatic send_item(input t_in_item it);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!dut_in_ready);
        @(negedge i_clk);
    endtask

    // tick with random pins; the busy bit is steered while a status high nibble is read
    function automatic t_in_item bus_tick();
        t_in_item it;
        it.op         = OP_TICK;
        it.byte_value = 8'($urandom);
        it.reg_select = 1'($urandom);
        it.pins_in    = 4'($urandom);
        if (seq_phase == PH_POLL_HI)
            it.pins_in[3] = ($urandom_range(99) < busy_pct);
        return it;
    endfunction

    function automatic t_in_item any_request();
        t_in_item it;
        it.op         = t_op'($urandom_range(1, 3));
        it.byte_value = 8'($urandom);
        it.reg_select = 1'($urandom);
        it.pins_in    = 4'($urandom);
        return it;
    endfunction

    // one request, then ticks (with random requests mixed in when noise is on) until the sequencer is back at idle
    task automatic run_request(input t_op op, input logic [7:0] value, input logic sel);
        t_in_item it;
        it.op         = op;
        it.byte_value = value;
        it.reg_select = sel;
        it.pins_in    = 4'($urandom);
        send_item(it);
        while (seq_phase != PH_IDLE) begin
            if (noise_pct != 0 && $urandom_range(99) < noise_pct)
                send_item(any_request());
            else
                send_item(bus_tick());
        end
    endtask

    // sender pauses until every predicted item has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (exp_levels_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_timing(input logic [19:0] pwr, input logic [19:0] igap,
                               input logic [7:0] pulse, input logic [7:0] ngap,
                               input logic [15:0] limit);
        settle();
        write_reg(CFG_POWER_ON_WAIT, pwr);
        write_reg(CFG_INIT_GAP, igap);
        write_reg(CFG_ENABLE_PULSE, 20'(pulse));
        write_reg(CFG_NIBBLE_GAP, 20'(ngap));
        write_reg(CFG_BUSY_TIMEOUT, 20'(limit));
    endtask

    task automatic reset_block();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    // reset timings: byte writes and reads, idle ticks, requests while busy
    task automatic test_default_transfers();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        busy_pct     = 0;
        send_item(bus_tick());
        run_request(OP_WRITE, 8'h00, 1'b0);
        run_request(OP_WRITE, 8'hFF, 1'b1);
        run_request(OP_READ, 8'h00, 1'b1);
        run_request(OP_READ, 8'hFF, 1'b0);
        send_item(bus_tick());
        // busy flag up now and then, no limit so the poll waits it out
        busy_pct = 60;
        run_request(OP_WRITE, 8'hA5, 1'b1);
        busy_pct = 0;
        // write, read and init offered mid-transfer get turned away
        noise_pct = 30;
        run_request(OP_WRITE, 8'h5A, 1'b0);
        run_request(OP_READ, 8'h3C, 1'b1);
        noise_pct = 0;
    endtask

    task automatic test_init_sequence();
        // everything zero: waits skipped and the raw pulses run together
        load_timing(20'd0, 20'd0, 8'd0, 8'd0, 16'd0);
        busy_pct = 0;
        run_request(OP_INIT, 8'hFF, 1'b1);
        // short timings, busy polls and rejected requests on the way
        load_timing(20'd7, 20'd3, 8'd2, 8'd1, 16'd0);
        busy_pct  = 40;
        noise_pct = 20;
        run_request(OP_INIT, 8'h00, 1'b0);
        noise_pct = 0;
        // every command byte ends its poll by timeout
        load_timing(20'd1, 20'd1, 8'd1, 8'd0, 16'd2);
        busy_pct = 100;
        run_request(OP_INIT, 8'h81, 1'b1);
        busy_pct = 0;
    endtask

    task automatic test_busy_timeout();
        load_timing(20'd3, 20'd2, 8'd1, 8'd0, 16'd1);
        busy_pct = 100;
        run_request(OP_WRITE, 8'h96, 1'b1);
        run_request(OP_READ, 8'h00, 1'b0);
        load_timing(20'd3, 20'd2, 8'd1, 8'd0, 16'd5);
        busy_pct = 70;
        run_request(OP_WRITE, 8'h69, 1'b0);
        run_request(OP_READ, 8'hFF, 1'b1);
        // largest limit keeps polling as long as the busy flag stays up
        load_timing(20'd3, 20'd2, 8'd1, 8'd0, 16'hFFFF);
        busy_pct = 100;
        run_request(OP_TICK, 8'h00, 1'b0);
        send_item(any_request());
        begin : saturate
            t_in_item it;
            it = '0;
            it.op         = OP_READ;
            it.reg_select = 1'b1;
            send_item(it);
        end
        repeat (LONG_POLL) send_item(bus_tick());
        busy_pct = 0;
        while (seq_phase != PH_IDLE) send_item(bus_tick());
    endtask

    // widest timings; the long init waits are only loaded, never run
    task automatic test_slow_timing();
        load_timing(20'hFFFFF, 20'hFFFFF, 8'd255, 8'd255, 16'hFFFF);
        busy_pct = 0;
        run_request(OP_WRITE, 8'hC3, 1'b1);
        run_request(OP_READ, 8'h3C, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering ticks, so the block backs up
    task automatic test_backpressure();
        load_timing(20'd2, 20'd1, 8'd1, 8'd1, 16'd0);
        busy_pct = 20;
        @(posedge i_clk);
        rx_hold_left = HOLD_OFF;
        @(negedge i_clk);
        repeat (12) run_request(OP_WRITE, 8'($urandom), 1'($urandom));
        settle();
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int unsigned pick;
        logic [7:0]  pulse;
        for (int ph = 0; ph < 4; ph++) begin
            pulse = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 20)) : 8'($urandom_range(3));
            load_timing(20'($urandom_range(12)), 20'($urandom_range(6)), pulse,
                        8'($urandom_range(3)),
                        ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(1, 30)));
            busy_pct     = $urandom_range(60);
            noise_pct    = 8;
            tx_idle_pct  = TX_IDLE[ph];
            rx_stall_pct = RX_STALL[ph];
            start        = work_items;
            while (work_items - start < PHASE_ITEMS) begin
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 2)) send_item(bus_tick());
                pick = $urandom_range(99);
                if (pick < 40)
                    run_request(OP_WRITE, 8'($urandom), 1'($urandom));
                else if (pick < 75)
                    run_request(OP_READ, 8'($urandom), 1'($urandom));
                else
                    run_request(OP_INIT, 8'($urandom), 1'($urandom));
            end
        end
        noise_pct    = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        reset_block();
        test_default_transfers();
        test_init_sequence();
        test_busy_timeout();
        test_slow_timing();
        test_backpressure();
        test_random_traffic();
        settle();
        repeat (END_WAIT) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
